[hdl/scanline_sample_unpacker_macros.svh]
// Assertion macros used by the top level of the scan-line sample unpacker.
`ifndef SCANLINE_SAMPLE_UNPACKER_MACROS_SVH
`define SCANLINE_SAMPLE_UNPACKER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SSU_CHECK_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSU_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ssu_pkg.sv]
// Types and constants of the scan-line sample unpacker.
package ssu_pkg;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_PACKING_MODE = 1'b0,
        CFG_PLANAR_WIDTH = 1'b1
    } t_cfg_index;

    localparam int unsigned CFG_DATA_W = 13;

    // Sample sizes in bits.
    localparam logic [4:0] PACKED_BITS = 5'd10;
    localparam logic [4:0] PLANAR_BITS = 5'd16;

    // Planar width handling.
    localparam logic [12:0] WIDTH_DEFAULT = 13'd2048;
    localparam logic [12:0] WIDTH_MAX     = 13'd4096;

    localparam logic [13:0] CLIP_VALUE = 14'h3fff;

    // One result item as it leaves the unpacking core.
    typedef struct packed {
        logic        valid;
        logic [13:0] sample_value;
        logic [2:0]  channel_index;
        logic [11:0] pixel_index;
        logic        line_last;
    } t_result;

endpackage

[hdl/ssu_core.sv]
// Unpacking core: bit store, skip and position counters, sample conditioning.
module ssu_core
    import ssu_pkg::*;
#(
    parameter int unsigned PACKED_PIXELS = 2048,
    parameter int unsigned SKIP_SAMPLES  = 15,
    parameter int unsigned CHANNELS      = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_data_byte,
    input  logic          i_line_start,
    input  logic          i_packing_mode,
    input  logic [12:0]   i_planar_width,
    output t_result       o_result,
    output logic          o_line_done
);

    logic [15:0] r_holder, n_holder;
    logic [3:0]  r_held,   n_held;
    logic [3:0]  r_skip,   n_skip;
    logic [2:0]  r_ch,     n_ch;
    logic [12:0] r_px,     n_px;
    logic        r_done,   n_done;

    logic [15:0] eff_holder;
    logic [3:0]  eff_held;
    logic [3:0]  eff_skip;
    logic [2:0]  eff_ch;
    logic [12:0] eff_px;
    logic        eff_done;

    logic        planar;
    logic [4:0]  size;
    logic [4:0]  held_sum;
    logic [4:0]  rem;
    logic [23:0] acc;
    logic [23:0] shifted;
    logic [15:0] raw;
    logic [15:0] keep_mask;
    logic [12:0] width;
    logic [12:0] pix_limit;
    logic [3:0]  ch_next;
    logic [12:0] px_next;
    logic [13:0] cond;

    always_comb begin
        // A line start clears the position before this byte is used.
        eff_holder = i_line_start ? 16'd0 : r_holder;
        eff_held   = i_line_start ? 4'd0  : r_held;
        eff_skip   = i_line_start ? 4'(SKIP_SAMPLES) : r_skip;
        eff_ch     = i_line_start ? 3'd0  : r_ch;
        eff_px     = i_line_start ? 13'd0 : r_px;
        eff_done   = i_line_start ? 1'b0  : r_done;

        planar   = i_packing_mode;
        size     = planar ? PLANAR_BITS : PACKED_BITS;
        held_sum = {1'b0, eff_held} + 5'd8;
        rem      = held_sum - size;
        acc      = {eff_holder, i_data_byte};
        shifted  = acc >> rem;
        raw      = planar ? shifted[15:0] : {6'd0, shifted[9:0]};
        keep_mask = (16'd1 << rem) - 16'd1;

        if (i_planar_width == 13'd0) begin
            width = WIDTH_DEFAULT;
        end else if (i_planar_width > WIDTH_MAX) begin
            width = WIDTH_MAX;
        end else begin
            width = i_planar_width;
        end
        pix_limit = planar ? width : 13'(PACKED_PIXELS);
        ch_next   = {1'b0, eff_ch} + 4'd1;
        px_next   = eff_px + 13'd1;

        // Negative values never occur in the stream; a set top bit reads as zero.
        if (raw[15]) begin
            cond = 14'd0;
        end else if (raw[14]) begin
            cond = CLIP_VALUE;
        end else begin
            cond = raw[13:0];
        end

        n_holder = r_holder;
        n_held   = r_held;
        n_skip   = r_skip;
        n_ch     = r_ch;
        n_px     = r_px;
        n_done   = r_done;
        o_result = '0;

        if (i_step) begin
            n_holder = eff_holder;
            n_held   = eff_held;
            n_skip   = eff_skip;
            n_ch     = eff_ch;
            n_px     = eff_px;
            n_done   = eff_done;
            if (!eff_done) begin
                if (held_sum < size) begin
                    n_holder = acc[15:0];
                    n_held   = held_sum[3:0];
                end else begin
                    n_holder = acc[15:0] & keep_mask;
                    n_held   = rem[3:0];
                    if (!planar && eff_skip != 4'd0) begin
                        n_skip = eff_skip - 4'd1;
                    end else if (eff_px >= pix_limit || {1'b0, eff_ch} >= 4'(CHANNELS)) begin
                        n_done = 1'b1;
                    end else begin
                        o_result.valid         = 1'b1;
                        o_result.sample_value  = cond;
                        o_result.channel_index = eff_ch;
                        o_result.pixel_index   = eff_px[11:0];
                        if (planar) begin
                            if (px_next >= width) begin
                                n_px = 13'd0;
                                if (ch_next >= 4'(CHANNELS)) begin
                                    n_done             = 1'b1;
                                    o_result.line_last = 1'b1;
                                end else begin
                                    n_ch = ch_next[2:0];
                                end
                            end else begin
                                n_px = px_next;
                            end
                        end else begin
                            if (ch_next >= 4'(CHANNELS)) begin
                                n_ch = 3'd0;
                                n_px = px_next;
                                if (px_next >= 13'(PACKED_PIXELS)) begin
                                    n_done             = 1'b1;
                                    o_result.line_last = 1'b1;
                                end
                            end else begin
                                n_ch = ch_next[2:0];
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holder <= 16'd0;
            r_held   <= 4'd0;
            r_skip   <= 4'd0;
            r_ch     <= 3'd0;
            r_px     <= 13'd0;
            r_done   <= 1'b1;
        end else begin
            r_holder <= n_holder;
            r_held   <= n_held;
            r_skip   <= n_skip;
            r_ch     <= n_ch;
            r_px     <= n_px;
            r_done   <= n_done;
        end
    end

    assign o_line_done = r_done;

endmodule

[hdl/scanline_sample_unpacker.sv]
// Top level of the scan-line sample unpacker: handshakes, configuration, checks.
//
// Usage. Scan-data bytes come in one per item on i_data_byte, with i_line_start
// set on the first byte of each line. Each byte yields zero or one conditioned
// sample item on the output channel, tagged with its channel, pixel and a flag
// on the final sample of the line. Both channels use valid and stall: an item
// moves at a clock edge where valid is high and stall is low.
// The path has two register stages, the input register and the output register.
// A byte taken into the input register is unpacked by the core when the output
// register can advance, and its sample is loaded into the output register.
// Throughput is one byte per cycle while the receiver does not stall; the core
// updates the bit store and position counters for each byte as it steps.
// When the receiver stalls, the held sample stays put and the input register
// can still take one more byte; only when both are full does o_stall rise.
// Configuration (packing mode, planar width) must be written by the user through the
// plain write port only while the block is idle; the block does not enforce this.
// Synchronous reset empties both registers, restores the register defaults
// (packed mode, width 2048) and leaves the core idle until a line start.
`include "scanline_sample_unpacker_macros.svh"

module scanline_sample_unpacker
    import ssu_pkg::*;
#(
    parameter int unsigned PACKED_PIXELS = 2048,
    parameter int unsigned SKIP_SAMPLES  = 15,
    parameter int unsigned CHANNELS      = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Byte input channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_line_start,
    // Sample output channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [13:0]           o_sample_value,
    output logic [2:0]            o_channel_index,
    output logic [11:0]           o_pixel_index,
    output logic                  o_line_last
);

    // Configuration registers.
    logic        r_packing_mode;
    logic [12:0] r_planar_width;

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;

    // Output register.
    logic        r_out_valid;
    t_result     r_out;

    logic        advance;
    logic        in_load;
    logic        core_step;
    logic        core_line_done;
    t_result     core_result;

    // The output register may be refilled when empty or when its item leaves now.
    assign advance   = !r_out_valid || !i_stall;
    assign core_step = r_in_valid && advance;
    assign in_load   = !r_in_valid || advance;
    assign o_stall   = !in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packing_mode <= 1'b0;
            r_planar_width <= WIDTH_DEFAULT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PACKING_MODE: r_packing_mode <= i_cfg_data[0];
                CFG_PLANAR_WIDTH: r_planar_width <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_line_start;
        end
    end

    ssu_core #(
        .PACKED_PIXELS (PACKED_PIXELS),
        .SKIP_SAMPLES  (SKIP_SAMPLES),
        .CHANNELS      (CHANNELS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (core_step),
        .i_data_byte    (r_in_byte),
        .i_line_start   (r_in_start),
        .i_packing_mode (r_packing_mode),
        .i_planar_width (r_planar_width),
        .o_result       (core_result),
        .o_line_done    (core_line_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= core_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sample_value  = r_out.sample_value;
    assign o_channel_index = r_out.channel_index;
    assign o_pixel_index   = r_out.pixel_index;
    assign o_line_last     = r_out.line_last;

    // The final sample of a line is only shown once the core has gone idle.
    `SSU_CHECK_NOW(a_last_ends_line, i_clk, i_rst_n, o_valid && o_line_last,
        core_line_done, "last sample shown while the core is still in a line")

    // Stalling the sender only happens with a byte waiting in the input register.
    `SSU_CHECK_NOW(a_stall_needs_byte, i_clk, i_rst_n, o_stall,
        r_in_valid && r_out_valid, "input stalled without both registers full")

    // A shown sample always names a channel that exists.
    `SSU_CHECK_NOW(a_channel_range, i_clk, i_rst_n, o_valid,
        {1'b0, o_channel_index} < 4'(CHANNELS), "channel index out of range")

    // An accepted byte lands in the input register.
    `SSU_CHECK_NEXT(a_accept_lands, i_clk, i_rst_n, i_valid && !o_stall,
        r_in_valid, "accepted byte missing from the input register")

endmodule
